[rtl/hfs_pkg.sv]
package hfs_pkg;

  // Grid and number format
  localparam int MAX_COLUMNS = 256;
  localparam int MAX_ROWS    = 256;
  localparam int FRAC_BITS   = 8;

  // Fixed field widths
  localparam int COORD_W  = 18;
  localparam int HEIGHT_W = 16;
  localparam int OUT_W    = 24;
  localparam int CFG_W    = 9;
  localparam int WIDX_W   = 10;
  localparam int CFG_IDX_W = 2;

  // Derived widths
  localparam int INT_W  = COORD_W - FRAC_BITS;
  localparam int COL_IW = $clog2(MAX_COLUMNS);
  localparam int ROW_IW = $clog2(MAX_ROWS);
  localparam int COL_SW = $clog2(MAX_COLUMNS + 1);
  localparam int ROW_SW = $clog2(MAX_ROWS + 1);
  localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VAL_W  = HEIGHT_W + FRAC_BITS + 1;
  localparam int MA_W   = VAL_W + 1;
  localparam int MB_W   = FRAC_BITS + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int STEP_W = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0]     GRID_SIZE_RESET  = CFG_W'(256);

  // Item kinds
  localparam logic ACT_WRITE  = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [1:0] {RAM_NOP, RAM_RD, RAM_WR} ram_op_t;
  typedef enum logic [1:0] {ADDR_00, ADDR_10, ADDR_01, ADDR_11} addr_sel_t;
  typedef enum logic [2:0] {CAP_NONE, CAP_V1, CAP_V2, CAP_V3, CAP_V4} cap_t;
  typedef enum logic [1:0] {MUL_NONE, MUL_X12, MUL_X34, MUL_Y} mul_t;
  typedef enum logic [1:0] {ACC_NONE, ACC_V12, ACC_V34} acc_t;
  typedef enum logic [2:0] {J_NEXT, J_WAIT_IN, J_IF_WRITE, J_EMIT, J_GOTO} jump_t;

  // One control word of the microprogram
  typedef struct packed {
    logic      take_in;
    logic      prep;
    ram_op_t   ram_op;
    addr_sel_t addr_sel;
    cap_t      cap;
    mul_t      mul;
    acc_t      acc;
    logic      emit;
    jump_t     cond;
    step_t     target;
  } ucode_t;

  // Status that steers the jumps
  typedef struct packed {
    logic in_valid;
    logic is_write;
    logic out_block;
  } seq_stat_t;

  // Program steps
  localparam step_t S_IDLE = STEP_W'(0);
  localparam step_t S_PREP = STEP_W'(1);
  localparam step_t S_RD00 = STEP_W'(2);
  localparam step_t S_RD10 = STEP_W'(3);
  localparam step_t S_RD01 = STEP_W'(4);
  localparam step_t S_RD11 = STEP_W'(5);
  localparam step_t S_MX12 = STEP_W'(6);
  localparam step_t S_MX34 = STEP_W'(7);
  localparam step_t S_A34  = STEP_W'(8);
  localparam step_t S_MY   = STEP_W'(9);
  localparam step_t S_FIN  = STEP_W'(10);
  localparam step_t S_WR   = STEP_W'(11);

  // Microprogram ROM
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t uc;
    uc.take_in  = 1'b0;
    uc.prep     = 1'b0;
    uc.ram_op   = RAM_NOP;
    uc.addr_sel = ADDR_00;
    uc.cap      = CAP_NONE;
    uc.mul      = MUL_NONE;
    uc.acc      = ACC_NONE;
    uc.emit     = 1'b0;
    uc.cond     = J_NEXT;
    uc.target   = S_IDLE;
    unique case (step)
      S_IDLE: begin
        uc.take_in = 1'b1;
        uc.cond    = J_WAIT_IN;
      end
      S_PREP: begin
        uc.prep   = 1'b1;
        uc.cond   = J_IF_WRITE;
        uc.target = S_WR;
      end
      S_RD00: begin
        uc.ram_op   = RAM_RD;
        uc.addr_sel = ADDR_00;
      end
      S_RD10: begin
        uc.ram_op   = RAM_RD;
        uc.addr_sel = ADDR_10;
        uc.cap      = CAP_V1;
      end
      S_RD01: begin
        uc.ram_op   = RAM_RD;
        uc.addr_sel = ADDR_01;
        uc.cap      = CAP_V2;
      end
      S_RD11: begin
        uc.ram_op   = RAM_RD;
        uc.addr_sel = ADDR_11;
        uc.cap      = CAP_V3;
      end
      S_MX12: begin
        uc.cap = CAP_V4;
        uc.mul = MUL_X12;
      end
      S_MX34: begin
        uc.acc = ACC_V12;
        uc.mul = MUL_X34;
      end
      S_A34: begin
        uc.acc = ACC_V34;
      end
      S_MY: begin
        uc.mul = MUL_Y;
      end
      S_FIN: begin
        uc.emit   = 1'b1;
        uc.cond   = J_EMIT;
        uc.target = S_IDLE;
      end
      S_WR: begin
        uc.ram_op   = RAM_WR;
        uc.addr_sel = ADDR_00;
        uc.emit     = 1'b1;
        uc.cond     = J_EMIT;
        uc.target   = S_IDLE;
      end
      default: begin
        uc.cond   = J_GOTO;
        uc.target = S_IDLE;
      end
    endcase
    return uc;
  endfunction

  // Size register in use: zero acts as one, large values cap at the maximum
  function automatic logic [COL_SW-1:0] col_size(input logic [CFG_W-1:0] rv);
    if (rv == '0) return COL_SW'(1);
    if (32'(rv) > 32'(MAX_COLUMNS)) return COL_SW'(MAX_COLUMNS);
    return COL_SW'(rv);
  endfunction

  function automatic logic [ROW_SW-1:0] row_size(input logic [CFG_W-1:0] rv);
    if (rv == '0) return ROW_SW'(1);
    if (32'(rv) > 32'(MAX_ROWS)) return ROW_SW'(MAX_ROWS);
    return ROW_SW'(rv);
  endfunction

  // Clamp a signed grid coordinate into [0, size-1]
  function automatic logic [COL_IW-1:0] clamp_col(input logic signed [INT_W:0] c,
                                                  input logic [COL_SW-1:0] size);
    if (c < 0) return '0;
    if (32'(c) >= 32'(size)) return COL_IW'(size - COL_SW'(1));
    return COL_IW'(c);
  endfunction

  function automatic logic [ROW_IW-1:0] clamp_row(input logic signed [INT_W:0] c,
                                                  input logic [ROW_SW-1:0] size);
    if (c < 0) return '0;
    if (32'(c) >= 32'(size)) return ROW_IW'(size - ROW_SW'(1));
    return ROW_IW'(c);
  endfunction

endpackage

[rtl/hfs_ram.sv]
module hfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Single port, read data registered
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/hfs_seq.sv]
module hfs_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  hfs_pkg::seq_stat_t stat,
  output hfs_pkg::ucode_t   uc
);

  hfs_pkg::step_t step_r;
  hfs_pkg::step_t step_nxt;

  // Fetch the control word of the current step
  assign uc = hfs_pkg::ucode_rom(step_r);

  // Pick the next step
  always_comb begin
    unique case (uc.cond)
      hfs_pkg::J_NEXT:     step_nxt = step_r + hfs_pkg::STEP_W'(1);
      hfs_pkg::J_WAIT_IN:  step_nxt = stat.in_valid ? step_r + hfs_pkg::STEP_W'(1) : step_r;
      hfs_pkg::J_IF_WRITE: step_nxt = stat.is_write ? uc.target
                                                    : step_r + hfs_pkg::STEP_W'(1);
      hfs_pkg::J_EMIT:     step_nxt = stat.out_block ? step_r : uc.target;
      hfs_pkg::J_GOTO:     step_nxt = uc.target;
      default:             step_nxt = hfs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= hfs_pkg::S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

[rtl/hfs_dp.sv]
module hfs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hfs_pkg::ucode_t                     uc,
  output hfs_pkg::seq_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [hfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hfs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [hfs_pkg::WIDX_W-1:0]          in_write_column,
  input  logic [hfs_pkg::WIDX_W-1:0]          in_write_row,
  input  logic signed [hfs_pkg::HEIGHT_W-1:0] in_write_height,
  input  logic signed [hfs_pkg::COORD_W-1:0]  in_sample_x,
  input  logic signed [hfs_pkg::COORD_W-1:0]  in_sample_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hfs_pkg::OUT_W-1:0]    out_height_out,
  output logic                                out_bounds_error,
  output logic                                ram_we,
  output logic [hfs_pkg::ADDR_W-1:0]          ram_addr,
  output logic [hfs_pkg::HEIGHT_W-1:0]        ram_wdata,
  input  logic [hfs_pkg::HEIGHT_W-1:0]        ram_rdata
);

  localparam int FB     = hfs_pkg::FRAC_BITS;
  localparam int INT_W  = hfs_pkg::INT_W;
  localparam int COL_IW = hfs_pkg::COL_IW;
  localparam int ROW_IW = hfs_pkg::ROW_IW;
  localparam int COL_SW = hfs_pkg::COL_SW;
  localparam int ROW_SW = hfs_pkg::ROW_SW;
  localparam int ADDR_W = hfs_pkg::ADDR_W;
  localparam int VAL_W  = hfs_pkg::VAL_W;
  localparam int MA_W   = hfs_pkg::MA_W;
  localparam int MB_W   = hfs_pkg::MB_W;
  localparam int PROD_W = hfs_pkg::PROD_W;
  localparam int OUT_W  = hfs_pkg::OUT_W;
  localparam int H_W    = hfs_pkg::HEIGHT_W;

  logic accept;
  logic out_block;
  logic out_load;

  // Configuration
  logic [hfs_pkg::CFG_W-1:0] cols_cfg_r;
  logic [hfs_pkg::CFG_W-1:0] rows_cfg_r;
  logic [COL_SW-1:0]         cols_s;
  logic [ROW_SW-1:0]         rows_s;

  // Latched item
  logic                            action_r;
  logic [hfs_pkg::WIDX_W-1:0]      wcol_r;
  logic [hfs_pkg::WIDX_W-1:0]      wrow_r;
  logic [H_W-1:0]                  wh_r;
  logic [hfs_pkg::COORD_W-1:0]     sx_r;
  logic [hfs_pkg::COORD_W-1:0]     sy_r;

  // Coordinate decode
  logic signed [INT_W:0]   fx0;
  logic signed [INT_W:0]   fy0;
  logic signed [INT_W:0]   fx1;
  logic signed [INT_W:0]   fy1;
  logic [FB-1:0]           xf;
  logic [FB-1:0]           yf;
  logic [COL_IW-1:0]       c0_nxt;
  logic [COL_IW-1:0]       c1_nxt;
  logic [ROW_IW-1:0]       r0_nxt;
  logic [ROW_IW-1:0]       r1_nxt;
  logic [ROW_IW+COL_SW-1:0] rb0_full;
  logic [ROW_IW+COL_SW-1:0] rb1_full;
  logic                    err_nxt;

  logic [COL_IW-1:0] c0_r;
  logic [COL_IW-1:0] c1_r;
  logic [ADDR_W-1:0] rb0_r;
  logic [ADDR_W-1:0] rb1_r;
  logic              err_r;

  // Arithmetic
  logic signed [H_W-1:0]    v1_r;
  logic signed [H_W-1:0]    v2_r;
  logic signed [H_W-1:0]    v3_r;
  logic signed [H_W-1:0]    v4_r;
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_nxt;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [VAL_W-1:0]  acc_base;
  logic signed [VAL_W-1:0]  acc_sum;
  logic signed [VAL_W-1:0]  v12_r;
  logic signed [VAL_W-1:0]  v34_r;
  logic signed [PROD_W-1:0] res;
  logic signed [OUT_W-1:0]  res_sat;
  logic                     res_fits;

  // Result register
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [OUT_W-1:0] out_height_r;
  logic                    out_err_r;

  assign accept    = in_valid && uc.take_in;
  assign in_stall  = !uc.take_in;
  assign out_block = out_valid_r && out_stall;
  assign out_load  = uc.emit && !out_block;

  assign stat.in_valid  = in_valid;
  assign stat.is_write  = (action_r == hfs_pkg::ACT_WRITE);
  assign stat.out_block = out_block;

  // Write size registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_cfg_r <= hfs_pkg::GRID_SIZE_RESET;
      rows_cfg_r <= hfs_pkg::GRID_SIZE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        hfs_pkg::REG_GRID_COLUMNS: cols_cfg_r <= cfg_wdata;
        hfs_pkg::REG_GRID_ROWS:    rows_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cols_s = hfs_pkg::col_size(cols_cfg_r);
  assign rows_s = hfs_pkg::row_size(rows_cfg_r);

  // Capture the accepted beat
  always_ff @(posedge clk) begin
    if (accept) begin
      action_r <= in_action;
      wcol_r   <= in_write_column;
      wrow_r   <= in_write_row;
      wh_r     <= in_write_height;
      sx_r     <= in_sample_x;
      sy_r     <= in_sample_y;
    end
  end

  // Split coordinates into grid point and fraction, clamp into the grid
  assign xf  = sx_r[FB-1:0];
  assign yf  = sy_r[FB-1:0];
  assign fx0 = (INT_W+1)'(signed'(sx_r[hfs_pkg::COORD_W-1:FB]));
  assign fy0 = (INT_W+1)'(signed'(sy_r[hfs_pkg::COORD_W-1:FB]));
  assign fx1 = fx0 + (INT_W+1)'(xf != '0);
  assign fy1 = fy0 + (INT_W+1)'(yf != '0);

  always_comb begin
    if (action_r == hfs_pkg::ACT_WRITE) begin
      c0_nxt = COL_IW'(wcol_r);
      r0_nxt = ROW_IW'(wrow_r);
    end else begin
      c0_nxt = hfs_pkg::clamp_col(fx0, cols_s);
      r0_nxt = hfs_pkg::clamp_row(fy0, rows_s);
    end
    c1_nxt  = hfs_pkg::clamp_col(fx1, cols_s);
    r1_nxt  = hfs_pkg::clamp_row(fy1, rows_s);
    err_nxt = (action_r == hfs_pkg::ACT_WRITE) &&
              ((32'(wcol_r) >= 32'(cols_s)) || (32'(wrow_r) >= 32'(rows_s)));
  end

  // Row bases: row times row pitch
  assign rb0_full = r0_nxt * cols_s;
  assign rb1_full = r1_nxt * cols_s;

  always_ff @(posedge clk) begin
    if (uc.prep) begin
      c0_r  <= c0_nxt;
      c1_r  <= c1_nxt;
      rb0_r <= ADDR_W'(rb0_full);
      rb1_r <= ADDR_W'(rb1_full);
      err_r <= err_nxt;
    end
  end

  // Grid memory address and write
  always_comb begin
    unique case (uc.addr_sel)
      hfs_pkg::ADDR_00: ram_addr = ADDR_W'(c0_r) + rb0_r;
      hfs_pkg::ADDR_10: ram_addr = ADDR_W'(c1_r) + rb0_r;
      hfs_pkg::ADDR_01: ram_addr = ADDR_W'(c0_r) + rb1_r;
      hfs_pkg::ADDR_11: ram_addr = ADDR_W'(c1_r) + rb1_r;
      default:          ram_addr = ADDR_W'(c0_r) + rb0_r;
    endcase
  end

  assign ram_we    = (uc.ram_op == hfs_pkg::RAM_WR) && !err_r;
  assign ram_wdata = wh_r;

  // Capture corner heights
  always_ff @(posedge clk) begin
    unique case (uc.cap)
      hfs_pkg::CAP_V1: v1_r <= ram_rdata;
      hfs_pkg::CAP_V2: v2_r <= ram_rdata;
      hfs_pkg::CAP_V3: v3_r <= ram_rdata;
      hfs_pkg::CAP_V4: v4_r <= ram_rdata;
      default: ;
    endcase
  end

  // Shared multiplier: difference times fraction
  always_comb begin
    unique case (uc.mul)
      hfs_pkg::MUL_X12: begin
        mul_a = MA_W'(v2_r) - MA_W'(v1_r);
        mul_b = signed'({1'b0, xf});
      end
      hfs_pkg::MUL_X34: begin
        mul_a = MA_W'(v4_r) - MA_W'(v3_r);
        mul_b = signed'({1'b0, xf});
      end
      hfs_pkg::MUL_Y: begin
        mul_a = MA_W'(v34_r) - MA_W'(v12_r);
        mul_b = signed'({1'b0, yf});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_nxt = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (uc.mul != hfs_pkg::MUL_NONE) begin
      prod_r <= prod_nxt;
    end
  end

  // Row blend: corner shifted up by the fraction bits, plus product
  assign acc_base = (uc.acc == hfs_pkg::ACC_V34) ? VAL_W'(v3_r) : VAL_W'(v1_r);
  assign acc_sum  = (acc_base <<< FB) + VAL_W'(prod_r);

  always_ff @(posedge clk) begin
    unique case (uc.acc)
      hfs_pkg::ACC_V12: v12_r <= acc_sum;
      hfs_pkg::ACC_V34: v34_r <= acc_sum;
      default: ;
    endcase
  end

  // Column blend with floor shift, then saturate
  assign res      = PROD_W'(v12_r) + (prod_r >>> FB);
  assign res_fits = (res[PROD_W-1:OUT_W-1] == '0) || (res[PROD_W-1:OUT_W-1] == '1);
  assign res_sat  = res_fits ? OUT_W'(res)
                  : (res[PROD_W-1] ? {1'b1, {(OUT_W-1){1'b0}}}
                                   : {1'b0, {(OUT_W-1){1'b1}}});

  // Result register: hold while stalled, load on an emit step
  always_comb begin
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_height_r <= (action_r == hfs_pkg::ACT_WRITE) ? '0 : res_sat;
      out_err_r    <= (action_r == hfs_pkg::ACT_WRITE) && err_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_height_out   = out_height_r;
  assign out_bounds_error = out_err_r;

  // Grid writes come only from write items
  a_write_only_for_writes: assert property (@(posedge clk) disable iff (!rst_n)
    (uc.ram_op == hfs_pkg::RAM_WR) |-> (action_r == hfs_pkg::ACT_WRITE))
    else $error("grid write issued for a sample item");

  // A flagged write reports height zero
  a_err_zero_height: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r) |-> (out_height_r == '0))
    else $error("bounds error beat carries a nonzero height");

  // A result appears only after an emit step
  a_result_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(uc.emit))
    else $error("result loaded outside an emit step");

  // One item at a time: no second beat right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !uc.take_in)
    else $error("input taken again right after an accept");

endmodule

[rtl/heightfield_bilinear_sampler.sv]
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_action, in_write_column, in_write_row,
//                                 in_write_height, in_sample_x, in_sample_y
// out      out_valid / out_stall  out_height_out, out_bounds_error
// cfg      cfg_we                 cfg_index, cfg_wdata
//
// After accept the microprogram runs a prep step; a sample then makes four reads through the
// single grid memory port and three products on the one shared multiplier before its emit
// step; a write goes straight to its write-and-emit step; only then is a new beat taken.
// Synchronous reset sets both size registers to 256; grid contents are not cleared.
// One result register sits at the output; while it is stalled and full the
// sequencer holds in its final step, and no new beat is taken until it loads.
module heightfield_bilinear_sampler (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [hfs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hfs_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic [hfs_pkg::WIDX_W-1:0]          in_write_column,
  input  logic [hfs_pkg::WIDX_W-1:0]          in_write_row,
  input  logic signed [hfs_pkg::HEIGHT_W-1:0] in_write_height,
  input  logic signed [hfs_pkg::COORD_W-1:0]  in_sample_x,
  input  logic signed [hfs_pkg::COORD_W-1:0]  in_sample_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hfs_pkg::OUT_W-1:0]    out_height_out,
  output logic                                out_bounds_error
);

  hfs_pkg::ucode_t    uc;
  hfs_pkg::seq_stat_t stat;

  logic                          ram_we;
  logic [hfs_pkg::ADDR_W-1:0]    ram_addr;
  logic [hfs_pkg::HEIGHT_W-1:0]  ram_wdata;
  logic [hfs_pkg::HEIGHT_W-1:0]  ram_rdata;

  // Step counter and microprogram
  hfs_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uc    (uc)
  );

  // Address, interpolation and result datapath
  hfs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .uc               (uc),
    .stat             (stat),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_column  (in_write_column),
    .in_write_row     (in_write_row),
    .in_write_height  (in_write_height),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_height_out   (out_height_out),
    .out_bounds_error (out_bounds_error),
    .ram_we           (ram_we),
    .ram_addr         (ram_addr),
    .ram_wdata        (ram_wdata),
    .ram_rdata        (ram_rdata)
  );

  // Height grid
  hfs_ram #(
    .WIDTH (hfs_pkg::HEIGHT_W),
    .DEPTH (hfs_pkg::DEPTH)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import hfs_pkg::*;

  localparam int     ONE_CELL    = 1 << FRAC_BITS;
  localparam int     ITEM_TARGET = 1675;
  localparam int     CYCLE_LIMIT = 600000;
  localparam int     SHOW_LIMIT  = 100;
  localparam longint OUT_HIGH    = (64'sd1 <<< (OUT_W - 1)) - 1;
  localparam longint OUT_LOW     = -(64'sd1 <<< (OUT_W - 1));

  typedef logic signed [HEIGHT_W-1:0] height_t;
  typedef logic signed [COORD_W-1:0]  coord_t;
  typedef logic [WIDX_W-1:0]          widx_t;
  typedef logic [CFG_W-1:0]           size_reg_t;

  localparam coord_t COORD_LOW  = {1'b1, {(COORD_W - 1){1'b0}}};
  localparam coord_t COORD_HIGH = {1'b0, {(COORD_W - 1){1'b1}}};

  typedef struct {
    logic    action;
    widx_t   col;
    widx_t   row;
    height_t h;
    coord_t  x;
    coord_t  y;
  } grid_item_t;

  typedef struct {
    logic signed [OUT_W-1:0] height;
    logic                    bounds_err;
  } grid_result_t;

  // Shadow of the height grid and size registers; predicts one result per beat
  class heightfield_checker;
    size_reg_t    col_reg;
    size_reg_t    row_reg;
    height_t      heights [DEPTH];
    bit           stored [DEPTH];
    grid_result_t due_results [$];
    int           fails;
    int           shown;

    function new();
      col_reg = GRID_SIZE_RESET;
      row_reg = GRID_SIZE_RESET;
      fails   = 0;
      shown   = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, size_reg_t val);
      if (idx == REG_GRID_COLUMNS) col_reg = val;
      else if (idx == REG_GRID_ROWS) row_reg = val;
    endfunction

    // Zero acts as one, anything past the maximum acts as the maximum
    function int size_in_use(size_reg_t rv, int cap);
      if (rv == '0) return 1;
      if (int'(rv) > cap) return cap;
      return int'(rv);
    endfunction

    function int cols_in_use();
      return size_in_use(col_reg, MAX_COLUMNS);
    endfunction

    function int rows_in_use();
      return size_in_use(row_reg, MAX_ROWS);
    endfunction

    function int clamp_idx(longint c, int size);
      if (c < 0) return 0;
      if (c >= longint'(size)) return size - 1;
      return int'(c);
    endfunction

    // Find the four surrounding entries and the fraction of each axis
    function void locate(coord_t x, coord_t y, output int i00, i10, i01, i11,
                         output longint xf, yf);
      longint lx, ly, fx, fy;
      int     c0, c1, r0, r1, cols, rows;
      cols = cols_in_use();
      rows = rows_in_use();
      lx = x;
      ly = y;
      fx = lx >>> FRAC_BITS;
      fy = ly >>> FRAC_BITS;
      xf = lx - fx * ONE_CELL;
      yf = ly - fy * ONE_CELL;
      c0 = clamp_idx(fx, cols);
      c1 = clamp_idx((xf != 0) ? fx + 1 : fx, cols);
      r0 = clamp_idx(fy, rows);
      r1 = clamp_idx((yf != 0) ? fy + 1 : fy, rows);
      i00 = c0 + r0 * cols;
      i10 = c1 + r0 * cols;
      i01 = c0 + r1 * cols;
      i11 = c1 + r1 * cols;
    endfunction

    function bit can_sample(coord_t x, coord_t y);
      int     i00, i10, i01, i11;
      longint xf, yf;
      locate(x, y, i00, i10, i01, i11, xf, yf);
      return stored[i00] && stored[i10] && stored[i01] && stored[i11];
    endfunction

    // Two-stage bilinear blend, second product floored by the shift
    function logic signed [OUT_W-1:0] interp_height(coord_t x, coord_t y);
      int     i00, i10, i01, i11;
      longint xf, yf, v1, v2, v3, v4, v12, v34, res;
      locate(x, y, i00, i10, i01, i11, xf, yf);
      v1 = heights[i00];
      v2 = heights[i10];
      v3 = heights[i01];
      v4 = heights[i11];
      v12 = v1 * ONE_CELL + (v2 - v1) * xf;
      v34 = v3 * ONE_CELL + (v4 - v3) * xf;
      res = v12 + (((v34 - v12) * yf) >>> FRAC_BITS);
      if (res > OUT_HIGH) res = OUT_HIGH;
      if (res < OUT_LOW) res = OUT_LOW;
      return OUT_W'(res);
    endfunction

    function void take_item(grid_item_t it);
      grid_result_t r;
      int           cols, idx;
      cols = cols_in_use();
      r.height     = '0;
      r.bounds_err = 1'b0;
      if (it.action == ACT_WRITE) begin
        if (int'(it.col) >= cols || int'(it.row) >= rows_in_use()) begin
          r.bounds_err = 1'b1;
        end else begin
          idx = int'(it.col) + int'(it.row) * cols;
          heights[idx] = it.h;
          stored[idx]  = 1'b1;
        end
      end else begin
        r.height = interp_height(it.x, it.y);
      end
      due_results.push_back(r);
    endfunction

    function void check_result(logic signed [OUT_W-1:0] h, logic err);
      grid_result_t exp_r;
      if (due_results.size() == 0) begin
        fails++;
        if (shown++ < SHOW_LIMIT)
          $display("%0t: result beat with none pending: height %0d, error %0b",
                   $time, h, err);
        return;
      end
      exp_r = due_results.pop_front();
      if (h !== exp_r.height) begin
        fails++;
        if (shown++ < SHOW_LIMIT)
          $display("%0t: height_out expected %0d, got %0d", $time, exp_r.height, h);
      end
      if (err !== exp_r.bounds_err) begin
        fails++;
        if (shown++ < SHOW_LIMIT)
          $display("%0t: bounds_error expected %0b, got %0b", $time,
                   exp_r.bounds_err, err);
      end
    endfunction

    function int pending();
      return due_results.size();
    endfunction
  endclass

  logic                    clk              = 1'b0;
  logic                    rst_n            = 1'b0;
  logic                    cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index        = REG_GRID_COLUMNS;
  size_reg_t               cfg_wdata        = '0;
  logic                    in_valid         = 1'b0;
  logic                    in_stall;
  logic                    in_action        = ACT_WRITE;
  widx_t                   in_write_column  = '0;
  widx_t                   in_write_row     = '0;
  height_t                 in_write_height  = '0;
  coord_t                  in_sample_x      = '0;
  coord_t                  in_sample_y      = '0;
  logic                    out_valid;
  logic                    out_stall        = 1'b1;
  logic signed [OUT_W-1:0] out_height_out;
  logic                    out_bounds_error;

  heightfield_checker board;
  int feed_gap_max = 0;
  int sink_gap_max = 0;
  int hold_left    = 0;
  int sent_items   = 0;
  int cycle_count  = 0;

  // Written region of the current grid setting; pw == 0 means none
  int cols_u, rows_u, pc, pr, pw, ph;

  heightfield_bilinear_sampler i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_write_column  (in_write_column),
    .in_write_row     (in_write_row),
    .in_write_height  (in_write_height),
    .in_sample_x      (in_sample_x),
    .in_sample_y      (in_sample_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_height_out   (out_height_out),
    .out_bounds_error (out_bounds_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check each result beat, then hold stall for a random number of cycles
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      board.check_result(out_height_out, out_bounds_error);
      hold_left = $urandom_range(0, sink_gap_max);
    end else if (hold_left != 0) begin
      hold_left--;
    end
    out_stall <= (hold_left != 0);
  end

  function automatic int gap_choice();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      default: return 19;
    endcase
  endfunction

  function automatic height_t pick_height();
    case ($urandom_range(0, 4))
      0: return {1'b0, {(HEIGHT_W - 1){1'b1}}};
      1: return {1'b1, {(HEIGHT_W - 1){1'b0}}};
      default: return HEIGHT_W'($urandom);
    endcase
  endfunction

  // Coordinate near the written region, around the grid, at an extreme, or anywhere
  function automatic coord_t pick_coord(int base, int span, int size_u);
    case ($urandom_range(0, 7))
      0: return COORD_W'($urandom);
      1, 2, 3: return COORD_W'(base * ONE_CELL - ONE_CELL +
                               int'($urandom_range(0, (span + 1) * ONE_CELL)));
      4: return COORD_W'(-2 * ONE_CELL + int'($urandom_range(0, (size_u + 2) * ONE_CELL)));
      5: return COORD_LOW;
      6: return COORD_HIGH;
      default: return COORD_W'(-1);
    endcase
  endfunction

  function automatic grid_item_t random_item();
    grid_item_t it;
    it.action = ACT_SAMPLE;
    it.col    = WIDX_W'($urandom);
    it.row    = WIDX_W'($urandom);
    it.h      = HEIGHT_W'($urandom);
    it.x      = COORD_W'($urandom);
    it.y      = COORD_W'($urandom);
    return it;
  endfunction

  // Present one beat after a random gap and hold it until accepted
  task automatic send_item(input grid_item_t it);
    int gap;
    gap = $urandom_range(0, feed_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= it.action;
    in_write_column <= it.col;
    in_write_row    <= it.row;
    in_write_height <= it.h;
    in_sample_x     <= it.x;
    in_sample_y     <= it.y;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.take_item(it);
    sent_items++;
  endtask

  task automatic do_write(input widx_t col, input widx_t row, input height_t h);
    grid_item_t it;
    it        = random_item();
    it.action = ACT_WRITE;
    it.col    = col;
    it.row    = row;
    it.h      = h;
    send_item(it);
  endtask

  task automatic do_sample(input coord_t x, input coord_t y);
    grid_item_t it;
    it        = random_item();
    it.action = ACT_SAMPLE;
    it.x      = x;
    it.y      = y;
    send_item(it);
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_grid(input size_reg_t cols, input size_reg_t rows);
    cfg_we    <= 1'b1;
    cfg_index <= REG_GRID_COLUMNS;
    cfg_wdata <= cols;
    @(posedge clk);
    board.set_reg(REG_GRID_COLUMNS, cols);
    cfg_index <= REG_GRID_ROWS;
    cfg_wdata <= rows;
    @(posedge clk);
    board.set_reg(REG_GRID_ROWS, rows);
    cfg_we    <= 1'b0;
  endtask

  // Sample only where all four corners hold written heights
  task automatic try_sample();
    coord_t x, y;
    bit     found;
    found = 1'b0;
    for (int t = 0; t < 16 && !found; t++) begin
      x = pick_coord(pc, pw, cols_u);
      y = pick_coord(pr, ph, rows_u);
      found = board.can_sample(x, y);
    end
    if (!found && pw != 0) begin
      x = COORD_W'(pc * ONE_CELL + int'($urandom_range(0, (pw - 1) * ONE_CELL)));
      y = COORD_W'(pr * ONE_CELL + int'($urandom_range(0, (ph - 1) * ONE_CELL)));
      found = 1'b1;
    end
    if (found)
      do_sample(x, y);
    else
      do_write(WIDX_W'($urandom_range(0, cols_u - 1)),
               WIDX_W'($urandom_range(0, rows_u - 1)), pick_height());
  endtask

  function automatic int pick_origin(int size, int span);
    case ($urandom_range(0, 2))
      0: return 0;
      1: return size - span;
      default: return $urandom_range(0, size - span);
    endcase
  endfunction

  // One grid setting: resize, fill a region unless old contents are reused, then mostly samples with some noise
  task automatic run_phase(input int p);
    size_reg_t c_reg, r_reg;
    int        budget;
    bit        keep_old;
    case (p)
      0: begin c_reg = '0;        r_reg = '0;        end
      1: begin c_reg = 9'd511;    r_reg = 9'd257;    end
      2: begin c_reg = 9'd1;      r_reg = 9'd256;    end
      3: begin c_reg = 9'd256;    r_reg = 9'd1;      end
      4: begin c_reg = 9'd256;    r_reg = 9'd256;    end
      5: begin c_reg = 9'd2;      r_reg = 9'd2;      end
      6: begin c_reg = 9'd3;      r_reg = 9'd4;      end
      default: begin
        if ($urandom_range(0, 4) == 0) begin
          c_reg = CFG_W'($urandom);
          r_reg = CFG_W'($urandom);
        end else begin
          c_reg = CFG_W'($urandom_range(1, 16));
          r_reg = CFG_W'($urandom_range(1, 16));
        end
      end
    endcase
    drain();
    write_grid(c_reg, r_reg);
    feed_gap_max = gap_choice();
    sink_gap_max = gap_choice();
    cols_u = board.cols_in_use();
    rows_u = board.rows_in_use();
    if (cols_u * rows_u <= 256) begin
      pc = 0;
      pr = 0;
      pw = cols_u;
      ph = rows_u;
    end else begin
      pw = $urandom_range(1, (cols_u < 6) ? cols_u : 6);
      ph = $urandom_range(1, (rows_u < 6) ? rows_u : 6);
      pc = pick_origin(cols_u, pw);
      pr = pick_origin(rows_u, ph);
    end
    // Reuse what earlier settings stored, read with the new row pitch
    keep_old = (p == 6) ||
               (p > 6 && cols_u * rows_u <= 256 && $urandom_range(0, 3) == 0);
    if (keep_old) begin
      pw = 0;
      ph = 0;
    end
    budget = sent_items + pw * ph + int'($urandom_range(40, 150));
    for (int r = 0; r < ph; r++)
      for (int c = 0; c < pw; c++)
        do_write(WIDX_W'(pc + c), WIDX_W'(pr + r), pick_height());
    while (sent_items < budget) begin
      case ($urandom_range(0, 9))
        0: do_write(WIDX_W'($urandom), WIDX_W'($urandom), pick_height());
        1: do_write(WIDX_W'($urandom_range(0, cols_u - 1)),
                    WIDX_W'($urandom_range(0, rows_u - 1)), pick_height());
        default: try_sample();
      endcase
    end
  endtask

  initial begin
    int p;
    board = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    feed_gap_max = 19;
    sink_gap_max = 19;

    // Directed: extreme heights at both grid corners, out-of-range writes
    do_write(10'd0,   10'd0,   16'sh7FFF);
    do_write(10'd1,   10'd0,   16'sh8000);
    do_write(10'd0,   10'd1,   16'sh8000);
    do_write(10'd1,   10'd1,   16'sh7FFF);
    do_write(10'd255, 10'd255, 16'sd1234);
    do_write(10'd254, 10'd255, -16'sd1);
    do_write(10'd255, 10'd254, 16'sh8000);
    do_write(10'd254, 10'd254, 16'sh7FFF);
    do_write(10'd256, 10'd0,   16'sd77);
    do_write(10'd0,   10'd256, 16'sd77);
    do_write(10'd1023, 10'd1023, 16'sh7FFF);

    // Directed: exact points, fractions, negative and past-edge coordinates
    do_sample(COORD_W'(0), COORD_W'(0));
    do_sample(COORD_W'(ONE_CELL / 2), COORD_W'(ONE_CELL / 2));
    do_sample(COORD_W'(1), COORD_W'(ONE_CELL - 1));
    do_sample(COORD_W'(ONE_CELL - 1), COORD_W'(1));
    do_sample(COORD_LOW, COORD_LOW);
    do_sample(COORD_W'(-1), COORD_W'(-1));
    do_sample(COORD_HIGH, COORD_HIGH);
    do_sample(COORD_W'(254 * ONE_CELL + ONE_CELL / 2),
              COORD_W'(254 * ONE_CELL + ONE_CELL / 4));
    do_sample(COORD_LOW, COORD_W'(ONE_CELL / 2));
    do_sample(COORD_HIGH, COORD_W'(254 * ONE_CELL + ONE_CELL / 2));
    do_sample(COORD_W'(3), COORD_LOW);

    // Random grid settings until enough beats have gone in
    p = 0;
    while (sent_items < ITEM_TARGET) begin
      run_phase(p);
      p++;
    end

    drain();
    repeat (20) @(posedge clk);
    if (board.fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
